>>> rtl/core/ppc32_integer_execute_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer execute unit.
// ---------------------------------------------------------------------------
`ifndef PPC32_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define PPC32_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define PIEU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property checked on the clock edge only.
`define PIEU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> rtl/core/pieu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pieu_pkg
// Operation codes and shared types of the integer execute unit.
// ---------------------------------------------------------------------------
package pieu_pkg;

    typedef enum logic [5:0] {
        OP_ADDI = 6'd0, OP_ADDIS = 6'd1, OP_ORI = 6'd2, OP_ORIS = 6'd3,
        OP_ANDI = 6'd4, OP_ANDIS = 6'd5, OP_XORI = 6'd6, OP_XORIS = 6'd7,
        OP_RLWNM = 6'd8, OP_RLWIMI = 6'd9, OP_RLWINM = 6'd10, OP_MULLI = 6'd11,
        OP_MULLW = 6'd12, OP_MULHW = 6'd13, OP_MULHWU = 6'd14, OP_NEG = 6'd15,
        OP_SUBF = 6'd16, OP_XOR = 6'd17, OP_OR = 6'd18, OP_ORC = 6'd19,
        OP_NOR = 6'd20, OP_NAND = 6'd21, OP_EQV = 6'd22, OP_AND = 6'd23,
        OP_ANDC = 6'd24, OP_SLW = 6'd25, OP_SRW = 6'd26, OP_ADD = 6'd27,
        OP_CMP = 6'd28, OP_CMPI = 6'd29, OP_CMPL = 6'd30, OP_CMPLI = 6'd31,
        OP_EXTSH = 6'd32, OP_EXTSB = 6'd33, OP_CNTLZW = 6'd34, OP_ADDIC = 6'd35,
        OP_ADDC = 6'd36, OP_ADDE = 6'd37, OP_ADDME = 6'd38, OP_ADDZE = 6'd39,
        OP_SUBFC = 6'd40, OP_SUBFE = 6'd41, OP_SUBFME = 6'd42, OP_SUBFZE = 6'd43,
        OP_SUBFIC = 6'd44
    } op_t;

    localparam logic [2:0] CC_LT = 3'd4;
    localparam logic [2:0] CC_GT = 3'd2;
    localparam logic [2:0] CC_EQ = 3'd1;

    // Kind of result that the last stage selects.
    typedef enum logic [1:0] {
        SEL_LOGIC = 2'd0,
        SEL_MUL_LO = 2'd1,
        SEL_MUL_HI = 2'd2
    } sel_t;

    typedef struct packed {
        logic       res_valid;
        logic       car_valid;
        logic       cmp_op;
        logic       rec;
        sel_t       sel;
    } ctl_t;

endpackage

>>> rtl/core/ppc32_integer_execute_unit.sv
`timescale 1ns / 1ps
// Throughput: one instruction per cycle unless stalled; the 33 by 33 multiplier
// sets the stage split (operand prep, multiply, result select and compare code).
// A stall holds every occupied stage; an empty stage still takes the item ahead.
// Reset (aresetn low, synchronous) clears all stage valid bits.
// ---------------------------------------------------------------------------
// ppc32_integer_execute_unit
// Three-stage PowerPC integer execute pipeline with stream handshakes.
// ---------------------------------------------------------------------------
module ppc32_integer_execute_unit
    import pieu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[5:0], a_value[37:6], b_value[69:38], s_value[101:70], ra_is_zero[102],
    // immediate[118:103], rotate amount[123:119], mask_begin[128:124],
    // mask_end[133:129], carry_in[134], record[135]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result[31:0], result_valid[32], carry_out[33], carry_valid[34],
    // compare_code[37:35], compare_valid[38], zero fill [39]
    output logic [39:0]  m_tdata
);

`include "ppc32_integer_execute_unit_macros.svh"

    logic [5:0]  op;
    logic [31:0] a_value, b_value, s_value;
    logic        ra_is_zero, carry_in, record;
    logic [15:0] immediate;
    logic [4:0]  rot_sh, mask_begin, mask_end;

    assign op           = s_tdata[5:0];
    assign a_value      = s_tdata[37:6];
    assign b_value      = s_tdata[69:38];
    assign s_value      = s_tdata[101:70];
    assign ra_is_zero   = s_tdata[102];
    assign immediate    = s_tdata[118:103];
    assign rot_sh       = s_tdata[123:119];
    assign mask_begin   = s_tdata[128:124];
    assign mask_end     = s_tdata[133:129];
    assign carry_in     = s_tdata[134];
    assign record       = s_tdata[135];

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // ---------------- stage 1: operand prep, logic, adder, rotate ----------
    logic [31:0] simm, ra0, rot, msk, lo_m, hi_m, logic_res;
    logic [32:0] sum, add_x, add_y;
    logic        add_c, cv, rv, rec, cmp_op, cmp_signed;
    logic [31:0] cmp_x, cmp_y;
    logic [4:0]  rot_n;
    logic [32:0] mul_x, mul_y;
    sel_t        sel;
    logic [5:0]  clz;

    always_comb begin
        simm = {{16{immediate[15]}}, immediate};
        ra0  = ra_is_zero ? 32'd0 : a_value;
        rot_n = (op == OP_RLWNM) ? b_value[4:0] : rot_sh;
        rot  = (s_value << rot_n) | (s_value >> (6'd32 - {1'b0, rot_n}));
        lo_m = 32'hFFFF_FFFF >> mask_begin;
        hi_m = ~(32'h7FFF_FFFF >> mask_end);
        msk  = (mask_begin <= mask_end) ? (lo_m & hi_m) : (lo_m | hi_m);
        clz  = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (s_value[i]) begin
                clz = 6'(31 - i);
            end
        end
        add_x = {1'b0, a_value};
        add_y = 33'd0;
        add_c = 1'b0;
        logic_res = 32'd0;
        cv = 1'b0; rv = 1'b1; rec = record; cmp_op = 1'b0; cmp_signed = 1'b1;
        cmp_x = a_value; cmp_y = b_value;
        sel = SEL_LOGIC;
        mul_x = {a_value[31], a_value};
        mul_y = {b_value[31], b_value};
        case (op)
            OP_ADDI:   begin logic_res = ra0 + simm; rec = 1'b0; end
            OP_ADDIS:  begin logic_res = ra0 + {immediate, 16'd0}; rec = 1'b0; end
            OP_ORI:    begin logic_res = s_value | {16'd0, immediate}; rec = 1'b0; end
            OP_ORIS:   begin logic_res = s_value | {immediate, 16'd0}; rec = 1'b0; end
            OP_ANDI:   begin logic_res = s_value & {16'd0, immediate}; rec = 1'b1; end
            OP_ANDIS:  begin logic_res = s_value & {immediate, 16'd0}; rec = 1'b1; end
            OP_XORI:   begin logic_res = s_value ^ {16'd0, immediate}; rec = 1'b0; end
            OP_XORIS:  begin logic_res = s_value ^ {immediate, 16'd0}; rec = 1'b0; end
            OP_RLWNM, OP_RLWINM: logic_res = rot & msk;
            OP_RLWIMI: logic_res = (rot & msk) | (a_value & ~msk);
            OP_MULLI:  begin sel = SEL_MUL_LO; mul_y = {simm[31], simm}; rec = 1'b0; end
            OP_MULLW:  sel = SEL_MUL_LO;
            OP_MULHW:  sel = SEL_MUL_HI;
            OP_MULHWU: begin
                sel = SEL_MUL_HI;
                mul_x = {1'b0, a_value};
                mul_y = {1'b0, b_value};
            end
            OP_NEG:    logic_res = 32'd0 - a_value;
            OP_SUBF:   logic_res = b_value - a_value;
            OP_XOR:    logic_res = s_value ^ b_value;
            OP_OR:     logic_res = s_value | b_value;
            OP_ORC:    logic_res = s_value | ~b_value;
            OP_NOR:    logic_res = ~(s_value | b_value);
            OP_NAND:   logic_res = ~(s_value & b_value);
            OP_EQV:    logic_res = ~(s_value ^ b_value);
            OP_AND:    logic_res = s_value & b_value;
            OP_ANDC:   logic_res = s_value & ~b_value;
            OP_SLW:    logic_res = b_value[5] ? 32'd0 : (s_value << b_value[4:0]);
            OP_SRW:    logic_res = b_value[5] ? 32'd0 : (s_value >> b_value[4:0]);
            OP_ADD:    logic_res = a_value + b_value;
            OP_CMP:    begin rv = 1'b0; rec = 1'b0; cmp_op = 1'b1; end
            OP_CMPI:   begin rv = 1'b0; rec = 1'b0; cmp_op = 1'b1; cmp_y = simm; end
            OP_CMPL:   begin rv = 1'b0; rec = 1'b0; cmp_op = 1'b1; cmp_signed = 1'b0; end
            OP_CMPLI:  begin
                rv = 1'b0; rec = 1'b0; cmp_op = 1'b1; cmp_signed = 1'b0;
                cmp_y = {16'd0, immediate};
            end
            OP_EXTSH:  logic_res = {{16{s_value[15]}}, s_value[15:0]};
            OP_EXTSB:  logic_res = {{24{s_value[7]}}, s_value[7:0]};
            OP_CNTLZW: logic_res = {26'd0, clz};
            OP_ADDIC:  begin cv = 1'b1; add_y = {1'b0, simm}; end
            OP_ADDC:   begin cv = 1'b1; add_y = {1'b0, b_value}; end
            OP_ADDE:   begin cv = 1'b1; add_y = {1'b0, b_value}; add_c = carry_in; end
            OP_ADDME:  begin cv = 1'b1; add_y = {1'b0, 32'hFFFF_FFFF}; add_c = carry_in; end
            OP_ADDZE:  begin cv = 1'b1; add_c = carry_in; end
            OP_SUBFC:  begin
                cv = 1'b1; add_x = {1'b0, ~a_value}; add_y = {1'b0, b_value}; add_c = 1'b1;
            end
            OP_SUBFE:  begin
                cv = 1'b1; add_x = {1'b0, ~a_value}; add_y = {1'b0, b_value};
                add_c = carry_in;
            end
            OP_SUBFME: begin
                cv = 1'b1; add_x = {1'b0, ~a_value}; add_y = {1'b0, 32'hFFFF_FFFF};
                add_c = carry_in;
            end
            OP_SUBFZE: begin cv = 1'b1; add_x = {1'b0, ~a_value}; add_c = carry_in; end
            OP_SUBFIC: begin
                cv = 1'b1; rec = 1'b0; add_x = {1'b0, ~a_value}; add_y = {1'b0, simm};
                add_c = 1'b1;
            end
            default:   begin rv = 1'b0; rec = 1'b0; end
        endcase
        sum = add_x + add_y + {32'd0, add_c};
    end

    ctl_t        ctl1_reg;
    logic [31:0] res1_reg;
    logic        co1_reg;
    logic [2:0]  cc1_reg;
    logic [32:0] mx1_reg, my1_reg;
    logic [2:0]  cc_next;

    always_comb begin
        if (cmp_signed ? ($signed(cmp_x) < $signed(cmp_y)) : (cmp_x < cmp_y)) begin
            cc_next = CC_LT;
        end else if (cmp_x == cmp_y) begin
            cc_next = CC_EQ;
        end else begin
            cc_next = CC_GT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_tvalid;
        end
        if (adv1) begin
            ctl1_reg <= '{res_valid: rv, car_valid: cv, cmp_op: cmp_op, rec: rec, sel: sel};
            res1_reg <= cv ? sum[31:0] : logic_res;
            co1_reg  <= cv & sum[32];
            cc1_reg  <= cc_next;
            mx1_reg  <= mul_x;
            my1_reg  <= mul_y;
        end
    end

    // ---------------- stage 2: multiply ------------------------------------
    ctl_t        ctl2_reg;
    logic [31:0] res2_reg;
    logic        co2_reg;
    logic [2:0]  cc2_reg;
    logic [65:0] prod2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
        if (adv2) begin
            ctl2_reg  <= ctl1_reg;
            res2_reg  <= res1_reg;
            co2_reg   <= co1_reg;
            cc2_reg   <= cc1_reg;
            prod2_reg <= 66'($signed(mx1_reg) * $signed(my1_reg));
        end
    end

    // ---------------- stage 3: select and record compare -------------------
    logic [31:0] fin;
    logic [2:0]  fin_cc;
    logic        fin_ccv;

    always_comb begin
        case (ctl2_reg.sel)
            SEL_MUL_LO: fin = prod2_reg[31:0];
            SEL_MUL_HI: fin = prod2_reg[63:32];
            default:    fin = res2_reg;
        endcase
        fin_ccv = ctl2_reg.cmp_op | (ctl2_reg.res_valid & ctl2_reg.rec);
        if (ctl2_reg.cmp_op) begin
            fin_cc = cc2_reg;
        end else if (!fin_ccv) begin
            fin_cc = 3'd0;
        end else if (fin[31]) begin
            fin_cc = CC_LT;
        end else if (fin == 32'd0) begin
            fin_cc = CC_EQ;
        end else begin
            fin_cc = CC_GT;
        end
    end

    logic [38:0] out3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
        if (adv3) begin
            out3_reg <= {fin_ccv, fin_cc, ctl2_reg.car_valid, co2_reg,
                         ctl2_reg.res_valid, ctl2_reg.res_valid ? fin : 32'd0};
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, out3_reg};

    `PIEU_ASSERT(a_stall_hold, v3_reg && !m_tready |=> v3_reg && $stable(out3_reg),
                 "result changed while stalled")
    `PIEU_ASSERT(a_cmp_no_reg, m_tvalid |-> !(m_tdata[32] && m_tdata[38] &&
                 m_tdata[37:35] == 3'd0), "compare strobe without code")
    `PIEU_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !v1_reg && !v2_reg && !v3_reg,
                        "pipeline not empty after reset")

endmodule

>>> sim/ppc32_integer_execute_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppc32_integer_execute_unit_tb
// Self-checking bench for the integer execute pipeline. Instructions are sent
// over the input stream, the outcome of each one is computed by an
// independent behavioral model and queued, and every result transfer is
// compared in full with the oldest queued outcome. Directed corner
// cases come first, followed by random instructions under three idling
// patterns, a long receiver stall and a full drain.
// ---------------------------------------------------------------------------
module ppc32_integer_execute_unit_tb;
    import pieu_pkg::*;

    typedef struct packed {
        logic        rec_bit;
        logic        ca_in;
        logic [4:0]  me;
        logic [4:0]  mb;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic        rz;
        logic [31:0] rs;
        logic [31:0] rb;
        logic [31:0] ra;
        logic [5:0]  opc;
    } insn_t;

    typedef struct packed {
        logic        pad;
        logic        cc_wr;
        logic [2:0]  cc;
        logic        ca_wr;
        logic        ca;
        logic        gpr_wr;
        logic [31:0] gpr;
    } outcome_t;

    localparam int STALL_LIMIT = 20000;
    localparam logic [5:0] OP_UNKNOWN_FIRST = 6'd45;
    localparam logic [5:0] OP_UNKNOWN_LAST  = 6'd63;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    outcome_t expected_q[$];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  mismatches = 0;
    int  checked = 0;
    int  sent = 0;
    int  quiet_cycles = 0;

    ppc32_integer_execute_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [2:0] signed_cmp(logic [31:0] x, logic [31:0] y);
        if ($signed(x) < $signed(y)) return CC_LT;
        if ($signed(x) > $signed(y)) return CC_GT;
        return CC_EQ;
    endfunction

    function automatic logic [31:0] rotate_mask(logic [4:0] mb, logic [4:0] me);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = 32'hFFFF_FFFF >> mb;
        hi = ~(32'h7FFF_FFFF >> me);
        return (mb <= me) ? (lo & hi) : (lo | hi);
    endfunction

    function automatic outcome_t execute_insn(insn_t i);
        outcome_t    o;
        logic [31:0] simm;
        logic [31:0] uimm;
        logic [31:0] ra0;
        logic [31:0] rot;
        logic [31:0] msk;
        logic [32:0] sum;
        logic [63:0] prod;
        logic [31:0] res;
        logic        rv;
        logic        cv;
        logic        rec;
        logic [2:0]  cc;
        logic        ccv;
        o = '0;
        simm = {{16{i.imm[15]}}, i.imm};
        uimm = {16'h0, i.imm};
        ra0 = i.rz ? 32'h0 : i.ra;
        msk = rotate_mask(i.mb, i.me);
        res = '0; rv = 1'b1; cv = 1'b0; rec = i.rec_bit; cc = '0; ccv = 1'b0; sum = '0;
        case (i.opc)
            OP_ADDI: begin res = ra0 + simm; rec = 1'b0; end
            OP_ADDIS: begin res = ra0 + {i.imm, 16'h0}; rec = 1'b0; end
            OP_ORI: begin res = i.rs | uimm; rec = 1'b0; end
            OP_ORIS: begin res = i.rs | {i.imm, 16'h0}; rec = 1'b0; end
            OP_ANDI: begin res = i.rs & uimm; rec = 1'b1; end
            OP_ANDIS: begin res = i.rs & {i.imm, 16'h0}; rec = 1'b1; end
            OP_XORI: begin res = i.rs ^ uimm; rec = 1'b0; end
            OP_XORIS: begin res = i.rs ^ {i.imm, 16'h0}; rec = 1'b0; end
            OP_RLWNM: begin
                rot = 32'({i.rs, i.rs} >> (32 - i.rb[4:0]));
                res = rot & msk;
            end
            OP_RLWIMI: begin
                rot = 32'({i.rs, i.rs} >> (32 - i.sh));
                res = (rot & msk) | (i.ra & ~msk);
            end
            OP_RLWINM: begin
                rot = 32'({i.rs, i.rs} >> (32 - i.sh));
                res = rot & msk;
            end
            OP_MULLI: begin res = i.ra * simm; rec = 1'b0; end
            OP_MULLW: res = i.ra * i.rb;
            OP_MULHW: begin
                prod = $signed({{32{i.ra[31]}}, i.ra}) * $signed({{32{i.rb[31]}}, i.rb});
                res = prod[63:32];
            end
            OP_MULHWU: begin
                prod = {32'h0, i.ra} * {32'h0, i.rb};
                res = prod[63:32];
            end
            OP_NEG: res = 32'h0 - i.ra;
            OP_SUBF: res = i.rb - i.ra;
            OP_XOR: res = i.rs ^ i.rb;
            OP_OR: res = i.rs | i.rb;
            OP_ORC: res = i.rs | ~i.rb;
            OP_NOR: res = ~(i.rs | i.rb);
            OP_NAND: res = ~(i.rs & i.rb);
            OP_EQV: res = ~(i.rs ^ i.rb);
            OP_AND: res = i.rs & i.rb;
            OP_ANDC: res = i.rs & ~i.rb;
            OP_SLW: res = i.rb[5] ? 32'h0 : (i.rs << i.rb[4:0]);
            OP_SRW: res = i.rb[5] ? 32'h0 : (i.rs >> i.rb[4:0]);
            OP_ADD: res = i.ra + i.rb;
            OP_CMP: begin rv = 1'b0; rec = 1'b0; ccv = 1'b1; cc = signed_cmp(i.ra, i.rb); end
            OP_CMPI: begin rv = 1'b0; rec = 1'b0; ccv = 1'b1; cc = signed_cmp(i.ra, simm); end
            OP_CMPL: begin
                rv = 1'b0; rec = 1'b0; ccv = 1'b1;
                cc = (i.ra < i.rb) ? CC_LT : (i.ra > i.rb) ? CC_GT : CC_EQ;
            end
            OP_CMPLI: begin
                rv = 1'b0; rec = 1'b0; ccv = 1'b1;
                cc = (i.ra < uimm) ? CC_LT : (i.ra > uimm) ? CC_GT : CC_EQ;
            end
            OP_EXTSH: res = {{16{i.rs[15]}}, i.rs[15:0]};
            OP_EXTSB: res = {{24{i.rs[7]}}, i.rs[7:0]};
            OP_CNTLZW: begin
                res = 32;
                for (int k = 31; k >= 0; k--) begin
                    if (i.rs[k]) begin
                        res = 31 - k;
                        break;
                    end
                end
            end
            OP_ADDIC: begin sum = {1'b0, i.ra} + simm; cv = 1'b1; end
            OP_ADDC: begin sum = {1'b0, i.ra} + i.rb; cv = 1'b1; end
            OP_ADDE: begin sum = {1'b0, i.ra} + i.rb + i.ca_in; cv = 1'b1; end
            OP_ADDME: begin sum = {1'b0, i.ra} + 32'hFFFF_FFFF + i.ca_in; cv = 1'b1; end
            OP_ADDZE: begin sum = {1'b0, i.ra} + i.ca_in; cv = 1'b1; end
            OP_SUBFC: begin sum = {1'b0, ~i.ra} + i.rb + 1'b1; cv = 1'b1; end
            OP_SUBFE: begin sum = {1'b0, ~i.ra} + i.rb + i.ca_in; cv = 1'b1; end
            OP_SUBFME: begin sum = {1'b0, ~i.ra} + 32'hFFFF_FFFF + i.ca_in; cv = 1'b1; end
            OP_SUBFZE: begin sum = {1'b0, ~i.ra} + i.ca_in; cv = 1'b1; end
            OP_SUBFIC: begin sum = {1'b0, ~i.ra} + simm + 1'b1; cv = 1'b1; rec = 1'b0; end
            default: begin rv = 1'b0; rec = 1'b0; end
        endcase
        if (cv) res = sum[31:0];
        if (rv && rec) begin
            ccv = 1'b1;
            cc = signed_cmp(res, 32'h0);
        end
        o.gpr = rv ? res : 32'h0;
        o.gpr_wr = rv;
        o.ca = cv ? sum[32] : 1'b0;
        o.ca_wr = cv;
        o.cc = ccv ? cc : 3'h0;
        o.cc_wr = ccv;
        return o;
    endfunction

    task automatic issue_insn(insn_t i);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= i;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q = {expected_q, execute_insn(i)};
        sent++;
    endtask

    function automatic insn_t random_insn(logic [5:0] opc);
        insn_t i;
        logic [31:0] pick [4];
        i = 136'({$urandom, $urandom, $urandom, $urandom, $urandom});
        i.opc = opc;
        pick[0] = 32'h0; pick[1] = 32'hFFFF_FFFF; pick[2] = 32'h8000_0000; pick[3] = 32'h7FFF_FFFF;
        if ($urandom_range(3) == 0) i.ra = pick[$urandom_range(3)];
        if ($urandom_range(3) == 0) i.rb = pick[$urandom_range(3)];
        if ($urandom_range(3) == 0) i.rs = pick[$urandom_range(3)];
        if ($urandom_range(3) == 0) i.rb[31:6] = '0;
        if ($urandom_range(4) == 0) i.rs = i.rs >> $urandom_range(31);
        if ($urandom_range(5) == 0) i.rb = i.ra;
        return i;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outcome_t got;
            outcome_t want;
            got = m_tdata;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result transfer %h", got);
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d: expected %h got %h", checked, want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || recv_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        insn_t i;
        for (int op = 0; op <= 44; op++) begin
            i = random_insn(6'(op));
            i.rec_bit = op[0];
            if (op % 3 == 0) begin
                i.ra = 32'hFFFF_FFFF; i.rb = 32'h0; i.imm = 16'h8000; i.ca_in = 1'b1;
            end
            issue_insn(i);
        end
        i = random_insn(OP_ADDI); i.rz = 1'b1; issue_insn(i);
        i = random_insn(OP_ADDIS); i.rz = 1'b1; issue_insn(i);
        i = random_insn(OP_SLW); i.rb = 32'h20; issue_insn(i);
        i = random_insn(OP_SRW); i.rb = 32'h3F; issue_insn(i);
        i = random_insn(OP_RLWINM); i.mb = 5'd28; i.me = 5'd3; issue_insn(i);
        i = random_insn(OP_CNTLZW); i.rs = 32'h0; issue_insn(i);
        i = random_insn(OP_CMP); i.ra = 32'h8000_0000; i.rb = 32'h1; issue_insn(i);
        i = random_insn(OP_CMPI); i.ra = 32'hFFFF_FFFF; i.imm = 16'hFFFF; issue_insn(i);
        i = random_insn(OP_SUBFIC); i.ra = 32'h0; i.imm = 16'h0; issue_insn(i);
        i = random_insn(OP_UNKNOWN_LAST); issue_insn(i);
        i = random_insn(OP_UNKNOWN_FIRST); issue_insn(i);
        drain_results();
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) issue_insn(random_insn($urandom_range(19) == 0 ?
            6'($urandom_range(OP_UNKNOWN_LAST, OP_UNKNOWN_FIRST)) :
            6'($urandom_range(OP_SUBFIC))));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(posedge aclk);
                recv_hold = 1'b0;
            end
            repeat (30) issue_insn(random_insn(6'($urandom_range(OP_SUBFIC))));
        join
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(110, 32, 67);
        test_backpressure();
        test_random(110, 67, 32);
        drain_results();
        test_random(110, 0, 0);
        drain_results();
        repeat (20) @(posedge aclk);
        $display("Sent %0d instructions, checked %0d results covering all operations,",
                 sent, checked);
        $display("unknown codes, idle patterns and a long output stall.");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pieu_pkg.sv
rtl/core/ppc32_integer_execute_unit.sv
sim/ppc32_integer_execute_unit_tb.sv
